FILE: design/camera_ray_generator_defines.svh
// ----------------------------------------------------------------------------
// Camera ray generator assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAMERA_RAY_GENERATOR_DEFINES_SVH
`define CAMERA_RAY_GENERATOR_DEFINES_SVH

// Property checked at every rising clock edge outside of reset.
`define CRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property whose consequent is checked in the cycle after the antecedent.
`define CRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/crg_pkg.sv
// ----------------------------------------------------------------------------
// Camera ray generator package
// Field widths, configuration register indexes and shared types.
// ----------------------------------------------------------------------------
package crg_pkg;

  localparam int unsigned COMP_W     = 21;
  localparam int unsigned VEC_W      = 63;
  localparam int unsigned EXT_W      = 32;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned NDC_W      = 18;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_CAM_POSITION = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_FORWARD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_RIGHT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CAM_UP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_EXTENT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VERT_EXTENT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ORTHO_MODE   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_SIZE   = 3'd7;

  // Camera setup as seen by the datapath; width and height are never zero.
  typedef struct packed {
    logic [VEC_W-1:0] position;
    logic [VEC_W-1:0] forward;
    logic [VEC_W-1:0] right;
    logic [VEC_W-1:0] up;
    logic [EXT_W-1:0] horiz_ext;
    logic [EXT_W-1:0] vert_ext;
    logic             ortho;
    logic [PIX_W-1:0] width;
    logic [PIX_W-1:0] height;
  } crg_cfg_t;

  // Queued pixel: numerators of the normalized device coordinates.
  typedef struct packed {
    logic signed [NDC_W-1:0] num_x;
    logic signed [NDC_W-1:0] num_y;
  } crg_item_t;

endpackage

FILE: design/camera_ray_generator.sv
// ----------------------------------------------------------------------------
// Camera ray generator
// Primary ray through a pixel center for a pinhole or orthographic camera.
// ----------------------------------------------------------------------------
// Datapath: a 119-stage pipeline behind the item queue, led by the 50-stage
// screen divider, the 32-stage square root and the 20-stage direction
// divider.
// Throughput: one ray per cycle while the output side takes results.
// Reset: asynchronous, active low; clears all valid state and loads the
// camera registers with their defaults (unit extents, 1x1 image).
// ----------------------------------------------------------------------------
module camera_ray_generator import crg_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Configuration write channel.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [CFG_DATA_W-1:0]    cfg_data_i,
  // Pixel input channel.
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [PIX_W-1:0]         pixel_x_i,
  input  logic [PIX_W-1:0]         pixel_y_i,
  // Ray output channel.
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [COMP_W-1:0] origin_x_o,
  output logic signed [COMP_W-1:0] origin_y_o,
  output logic signed [COMP_W-1:0] origin_z_o,
  output logic signed [COMP_W-1:0] dir_x_o,
  output logic signed [COMP_W-1:0] dir_y_o,
  output logic signed [COMP_W-1:0] dir_z_o,
  output logic                     dir_degenerate_o
);

  // Camera registers. A write transaction is always taken at once.
  logic [VEC_W-1:0] position_q, forward_q, right_q, up_q;
  logic [EXT_W-1:0] horiz_ext_q, vert_ext_q, image_size_q;
  logic             ortho_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q   <= '0;
      forward_q    <= '0;
      right_q      <= '0;
      up_q         <= '0;
      horiz_ext_q  <= 32'h0001_0000;
      vert_ext_q   <= 32'h0001_0000;
      ortho_q      <= 1'b0;
      image_size_q <= 32'h0001_0001;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_CAM_POSITION: position_q   <= cfg_data_i[VEC_W-1:0];
        CFG_CAM_FORWARD:  forward_q    <= cfg_data_i[VEC_W-1:0];
        CFG_CAM_RIGHT:    right_q      <= cfg_data_i[VEC_W-1:0];
        CFG_CAM_UP:       up_q         <= cfg_data_i[VEC_W-1:0];
        CFG_HORIZ_EXTENT: horiz_ext_q  <= cfg_data_i[EXT_W-1:0];
        CFG_VERT_EXTENT:  vert_ext_q   <= cfg_data_i[EXT_W-1:0];
        CFG_ORTHO_MODE:   ortho_q      <= cfg_data_i[0];
        CFG_IMAGE_SIZE:   image_size_q <= cfg_data_i[EXT_W-1:0];
        default: ;
      endcase
    end
  end

  // A zero width or height behaves as one, so the datapath never divides by
  // zero on the screen mapping.
  crg_cfg_t cfg;

  always_comb begin
    cfg.position  = position_q;
    cfg.forward   = forward_q;
    cfg.right     = right_q;
    cfg.up        = up_q;
    cfg.horiz_ext = horiz_ext_q;
    cfg.vert_ext  = vert_ext_q;
    cfg.ortho     = ortho_q;
    cfg.width     = (image_size_q[15:0] == '0) ? 16'd1 : image_size_q[15:0];
    cfg.height    = (image_size_q[31:16] == '0) ? 16'd1 : image_size_q[31:16];
  end

  // Front end: each accepted pixel becomes its pair of NDC numerators,
  // 2*x + 1 - W horizontally and H - 2*y - 1 vertically (row zero on top).
  crg_item_t item_in, item_out;
  logic      q_full, q_empty, q_pop;

  always_comb begin
    item_in.num_x = $signed(({1'b0, pixel_x_i, 1'b0} | 18'd1) - {2'b00, cfg.width});
    item_in.num_y = $signed({2'b00, cfg.height} - {1'b0, pixel_y_i, 1'b0} - 18'd1);
  end

  assign in_ready_o = !q_full;

  crg_queue #(.DEPTH(QUEUE_DEPTH), .W($bits(crg_item_t))) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i && in_ready_o),
    .data_i (item_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .data_o (item_out)
  );

  // Back end: the fully pipelined ray datapath, which stalls as a whole
  // only while its output register holds a result that is not taken.
  crg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .item_valid_i    (!q_empty),
    .item_i          (item_out),
    .item_pop_o      (q_pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .origin_x_o      (origin_x_o),
    .origin_y_o      (origin_y_o),
    .origin_z_o      (origin_z_o),
    .dir_x_o         (dir_x_o),
    .dir_y_o         (dir_y_o),
    .dir_z_o         (dir_z_o),
    .dir_degenerate_o(dir_degenerate_o)
  );

endmodule

FILE: design/crg_queue.sv
// ----------------------------------------------------------------------------
// Camera ray generator item queue
// Small FIFO that decouples pixel acceptance from the ray datapath.
// ----------------------------------------------------------------------------
`include "camera_ray_generator_defines.svh"

module crg_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned W     = 36
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output logic [W-1:0] data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `CRG_ASSERT(a_no_overflow, push_i |-> !full_o, "push into a full queue")
  `CRG_ASSERT(a_no_underflow, pop_i |-> !empty_o, "pop from an empty queue")
  `CRG_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

FILE: design/crg_div.sv
// ----------------------------------------------------------------------------
// Camera ray generator pipelined divider
// Restoring division, one quotient bit per stage, with a sideband carried along.
// ----------------------------------------------------------------------------
module crg_div #(
  parameter int unsigned DEN_W  = 16,
  parameter int unsigned Q_W    = 50,
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [DEN_W-1:0]  num_hi_i,
  input  logic [Q_W-1:0]    num_lo_i,
  input  logic [DEN_W-1:0]  den_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [Q_W-1:0]    quo_o,
  output logic [SIDE_W-1:0] side_o
);

  // The numerator is {num_hi_i, num_lo_i}; num_hi_i must be below den_i.
  logic [DEN_W-1:0]  rem_q  [Q_W];
  logic [Q_W-1:0]    nq_q   [Q_W];
  logic [DEN_W-1:0]  den_q  [Q_W];
  logic [SIDE_W-1:0] side_q [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic [DEN_W-1:0]  rem_in;
    logic [Q_W-1:0]    nq_in;
    logic [DEN_W-1:0]  den_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign rem_in  = num_hi_i;
      assign nq_in   = num_lo_i;
      assign den_in  = den_i;
      assign side_in = side_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign nq_in   = nq_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = {rem_in, nq_in[Q_W-1]};
    assign fits  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
        nq_q[k]   <= {nq_in[Q_W-2:0], fits};
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end
  end

  assign quo_o  = nq_q[Q_W-1];
  assign side_o = side_q[Q_W-1];

endmodule

FILE: design/crg_isqrt.sv
// ----------------------------------------------------------------------------
// Camera ray generator pipelined integer square root
// Floor square root of a 62-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module crg_isqrt #(
  parameter int unsigned SIDE_W = 1
) (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [61:0]       x_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic [30:0]       root_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam int unsigned STEPS = 32;

  logic [61:0]       x_q    [STEPS];
  logic [63:0]       res_q  [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [61:0]       x_in;
    logic [63:0]       res_in;
    logic [SIDE_W-1:0] side_in;
    logic [63:0]       trial;
    logic              fits;

    if (k == 0) begin : g_first
      assign x_in    = x_i;
      assign res_in  = '0;
      assign side_in = side_i;
    end else begin : g_next
      assign x_in    = x_q[k-1];
      assign res_in  = res_q[k-1];
      assign side_in = side_q[k-1];
    end

    assign trial = res_in + BIT;
    assign fits  = ({2'b00, x_in} >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= fits ? 62'({2'b00, x_in} - trial) : x_in;
        res_q[k]  <= fits ? (res_in >> 1) + BIT : res_in >> 1;
        side_q[k] <= side_in;
      end
    end
  end

  assign root_o = res_q[STEPS-1][30:0];
  assign side_o = side_q[STEPS-1];

endmodule

FILE: design/crg_back.sv
// ----------------------------------------------------------------------------
// Camera ray generator back end
// Ray datapath: screen scaling, basis products, origin and normalization.
// ----------------------------------------------------------------------------
`include "camera_ray_generator_defines.svh"

module crg_back import crg_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  crg_cfg_t                 cfg_i,
  input  logic                     item_valid_i,
  input  crg_item_t                item_i,
  output logic                     item_pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [COMP_W-1:0] origin_x_o,
  output logic signed [COMP_W-1:0] origin_y_o,
  output logic signed [COMP_W-1:0] origin_z_o,
  output logic signed [COMP_W-1:0] dir_x_o,
  output logic signed [COMP_W-1:0] dir_y_o,
  output logic signed [COMP_W-1:0] dir_z_o,
  output logic                     dir_degenerate_o
);

  localparam int unsigned SX_Q_W     = 50;
  localparam int unsigned DIR_Q_W    = 20;
  localparam int unsigned NORM_STEPS = 6;
  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned PIPE_DEPTH =
    2 + SX_Q_W + 5 + NORM_STEPS + 2 + SQRT_STEPS + 1 + DIR_Q_W + 1;
  localparam logic [SX_Q_W-1:0] S_LIMIT = SX_Q_W'(1) << 40;
  localparam logic signed [33:0] ORG_MAX = 34'sd1048575;
  localparam logic signed [33:0] ORG_MIN = -34'sd1048576;

  typedef struct packed {
    logic [2:0]             neg;
    logic                   degen;
    logic [2:0][COMP_W-1:0] org;
  } ray_side_t;

  typedef struct packed {
    logic [2:0][29:0] a;
    ray_side_t        rs;
  } sq_side_t;

  typedef struct packed {
    logic                   degen;
    logic [2:0][COMP_W-1:0] org;
  } tail_side_t;

  logic                  en;
  logic [PIPE_DEPTH-1:0] vld_q;

  // The whole pipeline advances together unless the final result is stalled.
  assign en          = !vld_q[PIPE_DEPTH-1] || out_ready_i;
  assign item_pop_o  = en && item_valid_i;
  assign out_valid_o = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], item_valid_i};
    end
  end

  // Magnitude of numerator times extent.
  logic [17:0] negx_v, negy_v;
  logic [48:0] magx_q, magy_q;
  logic        negx_a_q, negy_a_q, negx_b_q, negy_b_q;
  logic [SX_Q_W-1:0] numx_q, numy_q;

  assign negx_v = 18'd0 - item_i.num_x;
  assign negy_v = 18'd0 - item_i.num_y;

  always_ff @(posedge clk_i) begin
    if (en) begin
      negx_a_q <= item_i.num_x[17];
      negy_a_q <= item_i.num_y[17];
      magx_q   <= 49'(item_i.num_x[17] ? negx_v[16:0] : item_i.num_x[16:0]) *
                  49'(cfg_i.horiz_ext);
      magy_q   <= 49'(item_i.num_y[17] ? negy_v[16:0] : item_i.num_y[16:0]) *
                  49'(cfg_i.vert_ext);
      negx_b_q <= negx_a_q;
      negy_b_q <= negy_a_q;
      numx_q   <= SX_Q_W'(magx_q) + SX_Q_W'(cfg_i.width[15:1]);
      numy_q   <= SX_Q_W'(magy_q) + SX_Q_W'(cfg_i.height[15:1]);
    end
  end

  logic [SX_Q_W-1:0] qx, qy;
  logic              qx_neg, qy_neg;

  crg_div #(.DEN_W(PIX_W), .Q_W(SX_Q_W), .SIDE_W(1)) u_div_sx (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_hi_i('0),
    .num_lo_i(numx_q),
    .den_i   (cfg_i.width),
    .side_i  (negx_b_q),
    .quo_o   (qx),
    .side_o  (qx_neg)
  );

  crg_div #(.DEN_W(PIX_W), .Q_W(SX_Q_W), .SIDE_W(1)) u_div_sy (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_hi_i('0),
    .num_lo_i(numy_q),
    .den_i   (cfg_i.height),
    .side_i  (negy_b_q),
    .quo_o   (qy),
    .side_o  (qy_neg)
  );

  // Saturate the screen offsets and restore their signs.
  logic [40:0]        smagx, smagy;
  logic signed [41:0] sx_q, sy_q;

  assign smagx = (qx > S_LIMIT) ? S_LIMIT[40:0] : qx[40:0];
  assign smagy = (qy > S_LIMIT) ? S_LIMIT[40:0] : qy[40:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= qx_neg ? -$signed({1'b0, smagx}) : $signed({1'b0, smagx});
      sy_q <= qy_neg ? -$signed({1'b0, smagy}) : $signed({1'b0, smagy});
    end
  end

  logic signed [42:0] plr_q [3];
  logic signed [41:0] phr_q [3];
  logic signed [42:0] plu_q [3];
  logic signed [41:0] phu_q [3];
  logic signed [62:0] pr_q  [3];
  logic signed [62:0] pu_q  [3];
  logic signed [62:0] dv_q  [3];
  logic signed [31:0] ofr_q [3];
  logic signed [31:0] ofu_q [3];
  logic [62:0]        mag_q [3];
  logic               e2_neg_q [3];
  logic [COMP_W-1:0]  e2_org_q [3];
  logic               e2_degen_q;
  ray_side_t          e2;

  for (genvar i = 0; i < 3; i++) begin : g_comp
    logic signed [COMP_W-1:0] r, u, f, p;
    logic signed [62:0]       rnd_r, rnd_u, dvp;
    logic signed [33:0]       osum;

    assign r = $signed(cfg_i.right[COMP_W*i +: COMP_W]);
    assign u = $signed(cfg_i.up[COMP_W*i +: COMP_W]);
    assign f = $signed(cfg_i.forward[COMP_W*i +: COMP_W]);
    assign p = $signed(cfg_i.position[COMP_W*i +: COMP_W]);

    // Rounding half away from zero at bit 31 as one biased add.
    assign rnd_r = pr_q[i] + (pr_q[i][62] ? 63'sh3FFF_FFFF : 63'sh4000_0000);
    assign rnd_u = pu_q[i] + (pu_q[i][62] ? 63'sh3FFF_FFFF : 63'sh4000_0000);
    assign dvp   = (63'(f) <<< 16) + pr_q[i] + pu_q[i];
    assign osum  = 34'(p) + 34'(ofr_q[i]) + 34'(ofu_q[i]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        plr_q[i] <= $signed({1'b0, sx_q[20:0]}) * r;
        phr_q[i] <= $signed(sx_q[41:21]) * r;
        plu_q[i] <= $signed({1'b0, sy_q[20:0]}) * u;
        phu_q[i] <= $signed(sy_q[41:21]) * u;
        pr_q[i]  <= (63'(phr_q[i]) <<< 21) + 63'(plr_q[i]);
        pu_q[i]  <= (63'(phu_q[i]) <<< 21) + 63'(plu_q[i]);
        dv_q[i]  <= cfg_i.ortho ? 63'(f) : dvp;
        ofr_q[i] <= $signed(rnd_r[62:31]);
        ofu_q[i] <= $signed(rnd_u[62:31]);
        mag_q[i] <= dv_q[i][62] ? 63'(-dv_q[i]) : 63'(dv_q[i]);
        e2_neg_q[i] <= dv_q[i][62];
        if (!cfg_i.ortho) begin
          e2_org_q[i] <= p;
        end else if (osum > ORG_MAX) begin
          e2_org_q[i] <= ORG_MAX[COMP_W-1:0];
        end else if (osum < ORG_MIN) begin
          e2_org_q[i] <= ORG_MIN[COMP_W-1:0];
        end else begin
          e2_org_q[i] <= osum[COMP_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e2_degen_q <= ((dv_q[0] | dv_q[1] | dv_q[2]) == '0);
    end
  end

  always_comb begin
    e2.degen = e2_degen_q;
    for (int i = 0; i < 3; i++) begin
      e2.neg[i] = e2_neg_q[i];
      e2.org[i] = e2_org_q[i];
    end
  end

  // Normalizing shift: move the leading one of the OR of all magnitudes to
  // bit 62, halving the shift each stage.
  logic [62:0] nm_q   [NORM_STEPS][3];
  logic [62:0] nor_q  [NORM_STEPS];
  ray_side_t   nside_q [NORM_STEPS];

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    localparam int unsigned SH = 32 >> k;
    logic [62:0] m_in [3];
    logic [62:0] or_in;
    ray_side_t   side_in;
    logic        move;

    if (k == 0) begin : g_first
      assign m_in[0] = mag_q[0];
      assign m_in[1] = mag_q[1];
      assign m_in[2] = mag_q[2];
      assign or_in   = mag_q[0] | mag_q[1] | mag_q[2];
      assign side_in = e2;
    end else begin : g_next
      assign m_in[0] = nm_q[k-1][0];
      assign m_in[1] = nm_q[k-1][1];
      assign m_in[2] = nm_q[k-1][2];
      assign or_in   = nor_q[k-1];
      assign side_in = nside_q[k-1];
    end

    assign move = (or_in[62 -: SH] == '0);

    always_ff @(posedge clk_i) begin
      if (en) begin
        nor_q[k]    <= move ? or_in << SH : or_in;
        nm_q[k][0]  <= move ? m_in[0] << SH : m_in[0];
        nm_q[k][1]  <= move ? m_in[1] << SH : m_in[1];
        nm_q[k][2]  <= move ? m_in[2] << SH : m_in[2];
        nside_q[k]  <= side_in;
      end
    end
  end

  // Squares and their sum on the 30-bit normalized magnitudes.
  logic [59:0] sq_q [3];
  sq_side_t    sqs_q, sums_q;
  logic [61:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sqs_q.a[i] <= nm_q[NORM_STEPS-1][i][62:33];
        sq_q[i]    <= 60'(nm_q[NORM_STEPS-1][i][62:33]) *
                      60'(nm_q[NORM_STEPS-1][i][62:33]);
      end
      sqs_q.rs <= nside_q[NORM_STEPS-1];
      sum_q    <= 62'(sq_q[0]) + 62'(sq_q[1]) + 62'(sq_q[2]);
      sums_q   <= sqs_q;
    end
  end

  logic [30:0] len;
  sq_side_t    rt_side;

  crg_isqrt #(.SIDE_W($bits(sq_side_t))) u_isqrt (
    .clk_i (clk_i),
    .en_i  (en),
    .x_i   (sum_q),
    .side_i(sums_q),
    .root_o(len),
    .side_o(rt_side)
  );

  // Rounded division numerators: (mag << 19) + len / 2.
  logic [30:0]        hi_q [3];
  logic [DIR_Q_W-1:0] lo_q [3];
  logic [30:0]        len_q;
  logic [2:0]         pneg_q;
  tail_side_t         tail_q;

  for (genvar i = 0; i < 3; i++) begin : g_prep
    logic [49:0] full;
    assign full = 50'({rt_side.a[i], 19'd0}) + 50'(len[30:1]);

    always_ff @(posedge clk_i) begin
      if (en) begin
        hi_q[i] <= {1'b0, full[49:20]};
        lo_q[i] <= full[19:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      len_q        <= len;
      pneg_q       <= rt_side.rs.neg;
      tail_q.degen <= rt_side.rs.degen;
      tail_q.org   <= rt_side.rs.org;
    end
  end

  logic [DIR_Q_W-1:0] dq0, dq1, dq2;
  logic               dneg0, dneg1, dneg2;
  tail_side_t         dtail;

  crg_div #(.DEN_W(31), .Q_W(DIR_Q_W), .SIDE_W(1 + $bits(tail_side_t))) u_div_d0 (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_hi_i(hi_q[0]),
    .num_lo_i(lo_q[0]),
    .den_i   (len_q),
    .side_i  ({pneg_q[0], tail_q}),
    .quo_o   (dq0),
    .side_o  ({dneg0, dtail})
  );

  crg_div #(.DEN_W(31), .Q_W(DIR_Q_W), .SIDE_W(1)) u_div_d1 (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_hi_i(hi_q[1]),
    .num_lo_i(lo_q[1]),
    .den_i   (len_q),
    .side_i  (pneg_q[1]),
    .quo_o   (dq1),
    .side_o  (dneg1)
  );

  crg_div #(.DEN_W(31), .Q_W(DIR_Q_W), .SIDE_W(1)) u_div_d2 (
    .clk_i   (clk_i),
    .en_i    (en),
    .num_hi_i(hi_q[2]),
    .num_lo_i(lo_q[2]),
    .den_i   (len_q),
    .side_i  (pneg_q[2]),
    .quo_o   (dq2),
    .side_o  (dneg2)
  );

  // Output register; a degenerate direction is forced to zero.
  always_ff @(posedge clk_i) begin
    if (en) begin
      origin_x_o       <= $signed(dtail.org[0]);
      origin_y_o       <= $signed(dtail.org[1]);
      origin_z_o       <= $signed(dtail.org[2]);
      dir_degenerate_o <= dtail.degen;
      dir_x_o <= dtail.degen ? '0 : (dneg0 ? -$signed(21'(dq0)) : $signed(21'(dq0)));
      dir_y_o <= dtail.degen ? '0 : (dneg1 ? -$signed(21'(dq1)) : $signed(21'(dq1)));
      dir_z_o <= dtail.degen ? '0 : (dneg2 ? -$signed(21'(dq2)) : $signed(21'(dq2)));
    end
  end

  `CRG_ASSERT(a_degen_zero, out_valid_o && dir_degenerate_o |-> dir_x_o == 0 && dir_y_o == 0 && dir_z_o == 0, "degenerate ray with nonzero direction")
  `CRG_ASSERT(a_dir_bound, out_valid_o |-> dir_x_o <= 21'sd524288 && dir_x_o >= -21'sd524288 && dir_y_o <= 21'sd524288 && dir_y_o >= -21'sd524288 && dir_z_o <= 21'sd524288 && dir_z_o >= -21'sd524288, "direction component beyond unit length")
  `CRG_ASSERT_NEXT(a_pop_moves, item_pop_o, vld_q[0], "popped item lost from pipeline")

endmodule
